@@ hw/rtl/rev_pkg.sv @@
// Shared constants and types of the readiness event queue.
`default_nettype none
package rev_pkg;
  localparam int NUM_SOCKETS = 64;
  localparam int QUEUE_DEPTH = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int ID_W        = 6;
  localparam int EV_W        = 6;
  localparam int MAXEV_W     = 7;
  localparam int MAX_RES     = 64;
  localparam int TAW         = $clog2(NUM_SOCKETS);
  localparam int PW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] CMD_POST  = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_MOD   = 3'd2;
  localparam logic [2:0] CMD_DEL   = 3'd3;
  localparam logic [2:0] CMD_FETCH = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_EVENT  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_COALESCED = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_EXISTS    = 3'd4;
  localparam logic [2:0] ST_NOTREG    = 3'd5;

  localparam logic [EV_W-1:0] EV_ERR = 6'h08;
  localparam logic [EV_W-1:0] EV_HUP = 6'h10;

  typedef struct packed {
    logic [EV_W-1:0]       interest;
    logic [EV_W-1:0]       pending;
    logic [DATA_WIDTH-1:0] word;
  } rev_tbl_t;

  typedef struct packed {
    logic [ID_W-1:0]       sock;
    logic [EV_W-1:0]       ev;
    logic [DATA_WIDTH-1:0] data;
  } rev_ent_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic pop;
    logic look;
    logic eval;
    logic done;
  } rev_cmd_t;

  typedef struct packed {
    logic is_fetch;
    logic out_free;
    logic can_pop;
    logic eval_ok;
  } rev_sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/rev_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rev_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic                 re_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ hw/rtl/rev_ctrl.sv @@
// Sequencer for commands and for the fetch drain loop.
`default_nettype none
module rev_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rev_pkg::rev_sts_t sts_i,
  output rev_pkg::rev_cmd_t      cmd_o
);
  import rev_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_POP  = 6'b000100,
    S_LOOK = 6'b001000,
    S_EVAL = 6'b010000,
    S_DONE = 6'b100000
  } rev_state_e;

  rev_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.is_fetch ? S_POP : S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (sts_i.can_pop) begin
          cmd_o.pop = 1'b1;
          state_d = S_LOOK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.eval_ok) begin
          cmd_o.eval = 1'b1;
          state_d = S_POP;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
endmodule
`default_nettype wire

@@ hw/rtl/rev_datapath.sv @@
// Socket table, both rings, pointers, held event and result register.
`default_nettype none
module rev_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire rev_pkg::rev_cmd_t                    cmd_i,
  output rev_pkg::rev_sts_t                         sts_o,
  input  wire logic [2:0]                           command_i,
  input  wire logic                                 queue_select_i,
  input  wire logic [rev_pkg::ID_W-1:0]             socket_id_i,
  input  wire logic [rev_pkg::EV_W-1:0]             event_mask_i,
  input  wire logic [rev_pkg::DATA_WIDTH-1:0]       user_data_i,
  input  wire logic [rev_pkg::MAXEV_W-1:0]          max_events_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [1:0]                                kind_o,
  output logic [2:0]                                status_o,
  output logic [rev_pkg::ID_W-1:0]                  out_socket_id_o,
  output logic [rev_pkg::EV_W-1:0]                  out_event_mask_o,
  output logic [rev_pkg::DATA_WIDTH-1:0]            out_user_data_o,
  output logic                                      last_o
);
  import rev_pkg::*;

  localparam int TW = $bits(rev_tbl_t);
  localparam int RW = $bits(rev_ent_t);

  // latched command
  logic [2:0]            cmd_q;
  logic                  qsel_q;
  logic [ID_W-1:0]       id_q;
  logic [EV_W-1:0]       ev_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [MAXEV_W-1:0]    limit_q, limit_d;
  logic [MAXEV_W-1:0]    cnt_q;

  // ring pointers
  logic [PW-1:0] uhead_q, utail_q, shead_q, stail_q;
  logic [CW-1:0] ucnt_q, scnt_q;
  logic          sel_q;

  // socket table
  logic [NUM_SOCKETS-1:0] tv_q;
  logic                   tv_rd_q;
  logic [TW-1:0]          tbl_rdata;
  rev_tbl_t               tbl;
  logic                   tbl_we, tbl_re;
  logic [TAW-1:0]         tbl_waddr, tbl_raddr;
  rev_tbl_t               tbl_wdata;

  logic [RW-1:0] uring_rd, sring_rd;
  rev_ent_t      ent;
  logic          u_we, s_we, u_re, s_re;
  rev_ent_t      post_ent;

  // held event and result register
  rev_ent_t      held_q;
  logic          held_v_q;
  logic          out_valid_q;
  logic [1:0]    kind_q;
  logic [2:0]    status_q;
  rev_ent_t      res_q;
  logic          last_q;
  logic          out_free;

  // exec results
  logic [2:0] st;
  logic       x_we;
  rev_tbl_t   x_wdata;
  logic       post_ok;
  logic       oor_cmd, oor_ent, deliver, sel_now;
  logic       load;
  logic [1:0] load_kind;
  logic [2:0] load_status;
  rev_ent_t   load_res;
  logic       load_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign tbl      = tv_rd_q ? rev_tbl_t'(tbl_rdata) : '0;
  assign ent      = sel_q ? rev_ent_t'(sring_rd) : rev_ent_t'(uring_rd);

  always_comb begin
    if (max_events_i == '0) limit_d = MAXEV_W'(1);
    else if (max_events_i > MAXEV_W'(MAX_RES)) limit_d = MAXEV_W'(MAX_RES);
    else limit_d = max_events_i;
  end

  assign oor_cmd = {1'b0, id_q} >= (ID_W + 1)'(NUM_SOCKETS);
  assign oor_ent = {1'b0, ent.sock} >= (ID_W + 1)'(NUM_SOCKETS);

  always_comb begin
    st      = ST_OK;
    x_we    = 1'b0;
    x_wdata = tbl;
    post_ok = 1'b0;
    if (cmd_q <= CMD_DEL && oor_cmd) begin
      st = ST_NOTREG;
    end else begin
      case (cmd_q)
        CMD_POST: begin
          if (ev_q == '0) st = ST_EMPTY;
          else if ((tbl.pending & ev_q) != '0) st = ST_COALESCED;
          else if ((qsel_q ? scnt_q : ucnt_q) == CW'(QUEUE_DEPTH)) st = ST_FULL;
          else begin
            post_ok = 1'b1;
            x_we    = 1'b1;
            x_wdata.pending = tbl.pending | ev_q;
          end
        end
        CMD_ADD, CMD_MOD: begin
          if (cmd_q == CMD_ADD && tbl.interest != '0) st = ST_EXISTS;
          else if (cmd_q == CMD_MOD && tbl.interest == '0) st = ST_NOTREG;
          else begin
            x_we = 1'b1;
            x_wdata.interest = ev_q | EV_ERR | EV_HUP;
            x_wdata.word     = data_q;
          end
        end
        CMD_DEL: begin
          if (tbl.interest == '0) st = ST_NOTREG;
          else begin
            x_we = 1'b1;
            x_wdata.interest = '0;
          end
        end
        default: st = ST_OK;
      endcase
    end
  end

  assign deliver = !oor_ent && ((tbl.interest & ent.ev) != '0)
                   && ((tbl.pending & ent.ev) != '0);

  always_comb begin
    tbl_wdata = tbl;
    tbl_wdata.pending = tbl.pending & ~ent.ev;
    tbl_we    = cmd_i.eval && !oor_ent;
    tbl_waddr = ent.sock[TAW-1:0];
    if (cmd_i.exec) begin
      tbl_we    = x_we;
      tbl_wdata = x_wdata;
      tbl_waddr = id_q[TAW-1:0];
    end
  end

  assign tbl_re    = cmd_i.accept || cmd_i.look;
  assign tbl_raddr = cmd_i.accept ? socket_id_i[TAW-1:0] : ent.sock[TAW-1:0];

  rev_ram #(.W(TW), .D(NUM_SOCKETS)) u_tbl (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(tbl_wdata),
    .re_i(tbl_re), .raddr_i(tbl_raddr), .rdata_o(tbl_rdata)
  );

  assign post_ent = '{sock: id_q, ev: ev_q, data: tbl.word};
  assign u_we     = cmd_i.exec && post_ok && !qsel_q;
  assign s_we     = cmd_i.exec && post_ok && qsel_q;
  assign sel_now  = (ucnt_q == '0);
  assign u_re     = cmd_i.pop && !sel_now;
  assign s_re     = cmd_i.pop && sel_now;

  rev_ram #(.W(RW), .D(QUEUE_DEPTH)) u_uring (
    .clk_i, .we_i(u_we), .waddr_i(utail_q), .wdata_i(post_ent),
    .re_i(u_re), .raddr_i(uhead_q), .rdata_o(uring_rd)
  );

  rev_ram #(.W(RW), .D(QUEUE_DEPTH)) u_sring (
    .clk_i, .we_i(s_we), .waddr_i(stail_q), .wdata_i(post_ent),
    .re_i(s_re), .raddr_i(shead_q), .rdata_o(sring_rd)
  );

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign sts_o.is_fetch = (command_i == CMD_FETCH);
  assign sts_o.out_free = out_free;
  assign sts_o.can_pop  = (cnt_q < limit_q) && (ucnt_q != '0 || scnt_q != '0);
  assign sts_o.eval_ok  = !(deliver && held_v_q && !out_free);

  // result register load
  always_comb begin
    load        = 1'b0;
    load_kind   = KIND_STATUS;
    load_status = ST_OK;
    load_res    = '0;
    load_last   = 1'b1;
    if (cmd_i.exec) begin
      load        = 1'b1;
      load_status = st;
    end else if (cmd_i.eval && deliver && held_v_q) begin
      load      = 1'b1;
      load_kind = KIND_EVENT;
      load_res  = held_q;
      load_last = 1'b0;
    end else if (cmd_i.done) begin
      load = 1'b1;
      if (held_v_q) begin
        load_kind = KIND_EVENT;
        load_res  = held_q;
      end else begin
        load_kind = KIND_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uhead_q     <= '0;
      utail_q     <= '0;
      ucnt_q      <= '0;
      shead_q     <= '0;
      stail_q     <= '0;
      scnt_q      <= '0;
      tv_q        <= '0;
      tv_rd_q     <= 1'b0;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      sel_q       <= 1'b0;
    end else begin
      if (tbl_we) tv_q[tbl_waddr] <= 1'b1;
      if (tbl_re) tv_rd_q <= tv_q[tbl_raddr];
      if (u_we) begin
        utail_q <= wrap_inc(utail_q);
        ucnt_q  <= ucnt_q + CW'(1);
      end
      if (s_we) begin
        stail_q <= wrap_inc(stail_q);
        scnt_q  <= scnt_q + CW'(1);
      end
      if (u_re) begin
        uhead_q <= wrap_inc(uhead_q);
        ucnt_q  <= ucnt_q - CW'(1);
      end
      if (s_re) begin
        shead_q <= wrap_inc(shead_q);
        scnt_q  <= scnt_q - CW'(1);
      end
      if (cmd_i.pop) sel_q <= sel_now;
      if (cmd_i.accept) begin
        cnt_q    <= '0;
        held_v_q <= 1'b0;
      end else if (cmd_i.eval && deliver) begin
        cnt_q    <= cnt_q + MAXEV_W'(1);
        held_v_q <= 1'b1;
      end else if (cmd_i.done) begin
        held_v_q <= 1'b0;
      end
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= command_i;
      qsel_q  <= queue_select_i;
      id_q    <= socket_id_i;
      ev_q    <= event_mask_i;
      data_q  <= user_data_i;
      limit_q <= limit_d;
    end
    if (cmd_i.eval && deliver) held_q <= ent;
    if (load) begin
      kind_q   <= load_kind;
      status_q <= load_status;
      res_q    <= load_res;
      last_q   <= load_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign status_o         = status_q;
  assign out_socket_id_o  = res_q.sock;
  assign out_event_mask_o = res_q.ev;
  assign out_user_data_o  = res_q.data;
  assign last_o           = last_q;
endmodule
`default_nettype wire

@@ hw/rtl/readiness_event_queue.sv @@
// Readiness event queue: epoll-style interest table, two event rings, fetch.
//
// Input channel (in_valid_i/in_ready_o) takes one command beat: post, add,
// modify, delete or fetch. Output channel (out_valid_o/out_ready_i) gives
// result beats; last_o marks the final beat of each command.
// Post, add, modify and delete read the socket table on accept, then update
// it and load the result register. A fetch is accepted, then handles each
// popped ring entry by ring read, table read and table write-back, one entry
// at a time over the serial table port, and closes with its final beat.
// A delivered event is held one entry back so the final beat can carry last_o.
// One command is in flight at a time; in_ready_o is high only when idle.
// Reset empties both rings and marks every table entry unwritten, so all
// sockets read as unregistered with nothing pending; no clearing pass.
// When the receiver stalls the result register holds its beat and the
// block waits before loading the next one.
`default_nettype none
module readiness_event_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [2:0]                     command_i,
  input  wire logic                           queue_select_i,
  input  wire logic [rev_pkg::ID_W-1:0]       socket_id_i,
  input  wire logic [rev_pkg::EV_W-1:0]       event_mask_i,
  input  wire logic [rev_pkg::DATA_WIDTH-1:0] user_data_i,
  input  wire logic [rev_pkg::MAXEV_W-1:0]    max_events_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          kind_o,
  output logic [2:0]                          status_o,
  output logic [rev_pkg::ID_W-1:0]            out_socket_id_o,
  output logic [rev_pkg::EV_W-1:0]            out_event_mask_o,
  output logic [rev_pkg::DATA_WIDTH-1:0]      out_user_data_o,
  output logic                                last_o
);
  import rev_pkg::*;

  rev_cmd_t cmd;
  rev_sts_t sts;

  rev_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  rev_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .command_i, .queue_select_i, .socket_id_i, .event_mask_i, .user_data_i,
    .max_events_i, .out_valid_o, .out_ready_i, .kind_o, .status_o,
    .out_socket_id_o, .out_event_mask_o, .out_user_data_o, .last_o
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second command while busy");

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_NONE |-> last_o && status_o == ST_OK)
    else $error("empty fetch beat malformed");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_STATUS |-> last_o && out_event_mask_o == '0)
    else $error("status beat malformed");

  a_event_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_EVENT |-> out_event_mask_o != '0
    && status_o == ST_OK)
    else $error("delivered event with empty mask");
endmodule
`default_nettype wire
